// ----- rtl/core/lba_pkg.sv -----
// ----------------------------------------------------------------------------
// lba_pkg
// Shared widths, request and status codes, and the stack control and status
// types used by the arena stack allocator.
// ----------------------------------------------------------------------------
package lba_pkg;

	localparam int STACK_ENTRIES = 16;

	localparam int ADDR_W   = 32;
	localparam int REQ_W    = 21;
	localparam int SIZE_W   = REQ_W + 1;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int LIVE_W   = 5;

	localparam int DEPTH_W = $clog2(STACK_ENTRIES + 1);
	localparam int IDX_W   = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;

	localparam int ALIGN_BYTES = 4;
	localparam logic [SIZE_W-1:0] ALIGN_ADD  = SIZE_W'(ALIGN_BYTES - 1);
	localparam logic [SIZE_W-1:0] ALIGN_MASK = ~SIZE_W'(ALIGN_BYTES - 1);

	localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESET   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_REBASE  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic              push;
		logic              pop;
		logic              clear;
		logic [SIZE_W-1:0] wdata;
	} lba_stack_ctl_t;

	typedef struct packed {
		logic               full;
		logic               empty;
		logic [DEPTH_W-1:0] depth;
		logic [SIZE_W-1:0]  top;
	} lba_stack_sts_t;

endpackage

// ----- rtl/core/lba_size_stack.sv -----
// ----------------------------------------------------------------------------
// lba_size_stack
// LIFO of rounded allocation sizes with depth counter; presents the top entry.
// ----------------------------------------------------------------------------
module lba_size_stack
	import lba_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  lba_stack_ctl_t ctl,
	output lba_stack_sts_t sts
);

	logic [SIZE_W-1:0]  stack_q [STACK_ENTRIES];
	logic [DEPTH_W-1:0] depth_q;
	logic [IDX_W-1:0]   wr_idx;
	logic [IDX_W-1:0]   top_idx;

	assign wr_idx  = IDX_W'(depth_q);
	assign top_idx = IDX_W'(depth_q - DEPTH_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (ctl.clear) begin
			depth_q <= '0;
		end else if (ctl.push) begin
			depth_q <= depth_q + DEPTH_W'(1);
		end else if (ctl.pop) begin
			depth_q <= depth_q - DEPTH_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			stack_q[wr_idx] <= ctl.wdata;
		end
	end

	assign sts.full  = (depth_q == DEPTH_W'(STACK_ENTRIES));
	assign sts.empty = (depth_q == '0);
	assign sts.depth = depth_q;
	assign sts.top   = stack_q[top_idx];

endmodule

// ----- rtl/core/lifo_bump_allocator_top.sv -----
// ----------------------------------------------------------------------------
// lifo_bump_allocator_top
// Arena stack allocator: allocate, release last, reset and rebase requests
// against a bump cursor with a LIFO of rounded block sizes.
// ----------------------------------------------------------------------------
//  channel   signals                                 transfer
//  request   start, busy, kind, request_bytes        start & !busy
//  result    done, block_address, status, live_count  done (one cycle)
//  config    cfg_valid, cfg_ready, cfg_data           cfg_valid & cfg_ready
//
//  A request is registered on transfer and resolved in the next cycle; its
//  result is on the ports with done high for the cycle after that.
//  One request per cycle while busy is low: the cursor add/subtract and the stack push/pop
//  finish in the single processing stage, so back-to-back requests chain.
//  busy is high only while a configuration write is offered.
//  After reset: cursor and arena start are 0 and the stack is empty.
//  The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module lifo_bump_allocator_top
	import lba_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [KIND_W-1:0]   kind,
	input  logic [REQ_W-1:0]    request_bytes,
	output logic                done,
	output logic [ADDR_W-1:0]   block_address,
	output logic [STATUS_W-1:0] status,
	output logic [LIVE_W-1:0]   live_count,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ADDR_W-1:0]   cfg_data
);

	logic               valid_s1;
	logic [KIND_W-1:0]  kind_s1;
	logic [SIZE_W-1:0]  size_s1;

	logic [ADDR_W-1:0]  cursor_q;
	logic [ADDR_W-1:0]  arena_start_q;

	logic [ADDR_W-1:0]  cursor_nxt;
	logic [ADDR_W-1:0]  arena_start_nxt;
	logic [ADDR_W-1:0]  addr_nxt;
	logic [STATUS_W-1:0] status_nxt;
	logic [DEPTH_W-1:0] depth_nxt;

	logic [SIZE_W-1:0]  rounded;
	logic               accept;
	logic               cfg_xfer;

	lba_stack_ctl_t     stk_ctl;
	lba_stack_sts_t     stk_sts;

	assign busy      = cfg_valid;
	assign cfg_ready = ~valid_s1;
	assign accept    = start & ~busy;
	assign cfg_xfer  = cfg_valid & cfg_ready;

	// round the request up to the alignment
	assign rounded = ({1'b0, request_bytes} + ALIGN_ADD) & ALIGN_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			size_s1 <= rounded;
		end
	end

	lba_size_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (stk_ctl),
		.sts    (stk_sts)
	);

	always_comb begin
		cursor_nxt      = cursor_q;
		arena_start_nxt = arena_start_q;
		addr_nxt        = cursor_q;
		status_nxt      = ST_OK;
		depth_nxt       = stk_sts.depth;
		stk_ctl.push    = 1'b0;
		stk_ctl.pop     = 1'b0;
		stk_ctl.clear   = 1'b0;
		stk_ctl.wdata   = size_s1;
		if (valid_s1) begin
			case (kind_s1)
				KIND_ALLOC: begin
					if (stk_sts.full) begin
						status_nxt = ST_FULL;
					end else begin
						cursor_nxt   = cursor_q + ADDR_W'(size_s1);
						depth_nxt    = stk_sts.depth + DEPTH_W'(1);
						stk_ctl.push = 1'b1;
					end
				end
				KIND_RELEASE: begin
					if (stk_sts.empty) begin
						status_nxt = ST_EMPTY;
					end else begin
						cursor_nxt  = cursor_q - ADDR_W'(stk_sts.top);
						addr_nxt    = cursor_nxt;
						depth_nxt   = stk_sts.depth - DEPTH_W'(1);
						stk_ctl.pop = 1'b1;
					end
				end
				KIND_RESET: begin
					cursor_nxt    = arena_start_q;
					addr_nxt      = arena_start_q;
					depth_nxt     = '0;
					stk_ctl.clear = 1'b1;
				end
				KIND_REBASE: begin
					arena_start_nxt = cursor_q;
					depth_nxt       = '0;
					stk_ctl.clear   = 1'b1;
				end
				default: begin
					status_nxt = ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q      <= '0;
			arena_start_q <= '0;
		end else if (cfg_xfer) begin
			// a new base takes effect only with no allocation outstanding
			if (stk_sts.empty) begin
				cursor_q      <= cfg_data;
				arena_start_q <= cfg_data;
			end
		end else begin
			cursor_q      <= cursor_nxt;
			arena_start_q <= arena_start_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			block_address <= addr_nxt;
			status        <= status_nxt;
			live_count    <= LIVE_W'(depth_nxt);
		end
	end

endmodule

// ----- tb/tb_lifo_bump_allocator_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lifo_bump_allocator_top
// Self-checking bench for the arena stack allocator. A behavioral model of
// the cursor, arena start and size stack predicts every result; directed
// tests hit empty and full stack, wrap and oversized requests, then random
// fill/drain traffic runs under three sender idle profiles with base writes.
// ----------------------------------------------------------------------------
module tb_lifo_bump_allocator_top;
	import lba_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RANDOM_ITEMS = 1000;
	localparam int DRAIN_CYCLES = 8;
	// ~1030 requests plus drains stay well under this limit
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic [ADDR_W-1:0]   addr;
		logic [STATUS_W-1:0] status;
		logic [LIVE_W-1:0]   live;
	} arena_result_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                start         = 1'b0;
	logic [KIND_W-1:0]   kind          = KIND_ALLOC;
	logic [REQ_W-1:0]    request_bytes = '0;
	logic                cfg_valid     = 1'b0;
	logic [ADDR_W-1:0]   cfg_data      = '0;
	logic                busy;
	logic                done;
	logic                cfg_ready;
	logic [ADDR_W-1:0]   block_address;
	logic [STATUS_W-1:0] status;
	logic [LIVE_W-1:0]   live_count;

	// predicted allocator state
	logic [ADDR_W-1:0] bump_ptr     = '0;
	logic [ADDR_W-1:0] arena_origin = '0;
	logic [SIZE_W-1:0] block_sizes[$];

	arena_result_t pending_results[$];

	int mismatches      = 0;
	int results_seen    = 0;
	int cycle_count     = 0;
	int sender_idle_pct = 0;
	int full_hits       = 0;
	int empty_hits      = 0;
	int cfg_writes      = 0;
	int kind_hits[4]    = '{0, 0, 0, 0};

	lifo_bump_allocator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.request_bytes (request_bytes),
		.done          (done),
		.block_address (block_address),
		.status        (status),
		.live_count    (live_count),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic arena_result_t predict_request(input logic [KIND_W-1:0] k,
			input logic [REQ_W-1:0] nbytes);
		arena_result_t res;
		logic [SIZE_W-1:0] rounded;
		res.status = ST_OK;
		rounded = ({1'b0, nbytes} + ALIGN_ADD) & ALIGN_MASK;
		case (k)
			KIND_ALLOC: begin
				res.addr = bump_ptr;
				if (block_sizes.size() >= STACK_ENTRIES) begin
					res.status = ST_FULL;
					full_hits++;
				end else begin
					bump_ptr = bump_ptr + ADDR_W'(rounded);
					block_sizes.push_back(rounded);
				end
			end
			KIND_RELEASE: begin
				if (block_sizes.size() == 0) begin
					res.status = ST_EMPTY;
					empty_hits++;
				end else begin
					bump_ptr = bump_ptr - ADDR_W'(block_sizes.pop_back());
				end
				res.addr = bump_ptr;
			end
			KIND_RESET: begin
				block_sizes.delete();
				bump_ptr = arena_origin;
				res.addr = bump_ptr;
			end
			default: begin
				// rebase: the cursor becomes the new origin, then empty
				arena_origin = bump_ptr;
				block_sizes.delete();
				res.addr = bump_ptr;
			end
		endcase
		res.live = LIVE_W'(block_sizes.size());
		return res;
	endfunction

	function automatic void load_base_register(input logic [ADDR_W-1:0] value);
		// origin and cursor follow the register only with nothing outstanding
		if (block_sizes.size() == 0) begin
			arena_origin = value;
			bump_ptr = value;
		end
	endfunction

	task automatic send_request(input logic [KIND_W-1:0] k, input logic [REQ_W-1:0] nbytes);
		// idle the sender for a random stretch before each request
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		request_bytes <= nbytes;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_request(k, nbytes));
		kind_hits[k]++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_arena_base(input logic [ADDR_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		load_base_register(value);
		cfg_writes++;
	endtask

	always @(posedge clk) begin : check_results
		arena_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: block_address %h", block_address);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				if (block_address !== want.addr) begin
					$error("block_address: expected %h, got %h", want.addr, block_address);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (live_count !== want.live) begin
					$error("live_count: expected %0d, got %0d", want.live, live_count);
					mismatches++;
				end
			end
		end
	end

	task automatic test_register_extremes();
		write_arena_base(32'hFFFF_FFFC);
	endtask

	task automatic test_edge_requests();
		// base sits just below the wrap point
		send_request(KIND_RELEASE, '1);
		send_request(KIND_ALLOC, '0);
		send_request(KIND_ALLOC, 21'd1);
		send_request(KIND_ALLOC, 21'd8);
		send_request(KIND_ALLOC, '1);
		send_request(KIND_ALLOC, 21'h10_0000);
		send_request(KIND_RELEASE, 21'h0A_5A5A);
		send_request(KIND_REBASE, 21'h15_A5A5);
		send_request(KIND_RELEASE, '0);
		send_request(KIND_ALLOC, 21'd3);
		send_request(KIND_RESET, '1);
	endtask

	task automatic test_stack_full();
		for (int i = 0; i <= STACK_ENTRIES; i++) begin
			send_request(KIND_ALLOC, REQ_W'(i * 5 + 1));
		end
		// write with blocks live: origin must stay put until the stack empties
		write_arena_base('0);
		send_request(KIND_RESET, '0);
		write_arena_base('0);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int count,
			input logic [ADDR_W-1:0] base);
		int pick;
		int alloc_pct;
		logic [KIND_W-1:0] k;
		logic [REQ_W-1:0] nbytes;
		write_arena_base(base);
		sender_idle_pct = idle_pct;
		for (int n = 0; n < count; n++) begin
			// alternate fill and drain stretches so both stack ends are reached
			alloc_pct = ((n / 24) % 2 == 0) ? 75 : 25;
			pick = $urandom_range(0, 99);
			if (pick < alloc_pct) begin
				k = KIND_ALLOC;
			end else if (pick < 95) begin
				k = KIND_RELEASE;
			end else if (pick < 97) begin
				k = KIND_RESET;
			end else begin
				k = KIND_REBASE;
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				nbytes = REQ_W'($urandom_range(0, 64));
			end else if (pick < 90) begin
				nbytes = REQ_W'($urandom_range(0, 1048576));
			end else begin
				nbytes = REQ_W'($urandom);
			end
			send_request(k, nbytes);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_extremes();
		test_edge_requests();
		test_stack_full();
		test_random_traffic(34, RANDOM_ITEMS / 3, ADDR_W'($urandom));
		test_random_traffic(62, RANDOM_ITEMS / 3, 32'hFFFF_FF00);
		test_random_traffic(0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), ADDR_W'($urandom));
		drain_results();
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			mismatches++;
		end
		$display("ran %0d alloc, %0d release, %0d reset, %0d rebase requests; %0d results checked",
			kind_hits[KIND_ALLOC], kind_hits[KIND_RELEASE], kind_hits[KIND_RESET],
			kind_hits[KIND_REBASE], results_seen);
		$display("stack full %0d times, empty release %0d times, %0d base writes, %0d mismatches",
			full_hits, empty_hits, cfg_writes, mismatches);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
